### hw/rtl/mfpc_pkg.sv
package mfpc_pkg;

  localparam int SETTLE_COUNT = 100;
  localparam int SAMPLE_BITS  = 10;

  localparam logic [9:0] SAMPLE_MASK = 10'((1 << SAMPLE_BITS) - 1);
  localparam logic [6:0] SETTLE_MAX  = 7'(SETTLE_COUNT);
  localparam logic [6:0] SETTLE_SAT  = 7'd127;

  // divide by 100 as multiply by reciprocal, exact for products below 2^17
  localparam int          RECIP_SHIFT = 24;
  localparam logic [17:0] PCT_RECIP   = 18'((1 << RECIP_SHIFT) / 100 + 1);

  localparam int WIN_W = 13;

  localparam logic [1:0] DIR_STOP = 2'd0;
  localparam logic [1:0] DIR_UP   = 2'd1;
  localparam logic [1:0] DIR_DOWN = 2'd2;

  localparam logic OP_START  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  localparam logic [2:0] REG_FADER_MIN  = 3'd0;
  localparam logic [2:0] REG_FADER_MAX  = 3'd1;
  localparam logic [2:0] REG_TOLERANCE  = 3'd2;
  localparam logic [2:0] REG_SPEED_FAR  = 3'd3;
  localparam logic [2:0] REG_SPEED_MID  = 3'd4;
  localparam logic [2:0] REG_SPEED_NEAR = 3'd5;
  localparam logic [2:0] REG_DIST_FAR   = 3'd6;
  localparam logic [2:0] REG_DIST_NEAR  = 3'd7;

  typedef struct packed {
    logic       op;
    logic [6:0] target_percent;
    logic [9:0] sample;
  } fader_in_t;

  typedef struct packed {
    logic [1:0] direction;
    logic [7:0] duty;
    logic       settled;
  } fader_out_t;

endpackage

### hw/rtl/motor_fader_position_control_top.sv
// motorized fader position controller
// input channel (in_valid_i / in_stall_o / in_data_i): each transaction is either a
// start (op 0: target percent plus the first position sample) or a new position
// sample (op 1). every input transaction gives exactly one output transaction
// (out_valid_o / out_stall_i / out_data_o) with motor direction, pwm duty and
// the settled flag.
// from input accept to output valid a transaction passes through: product of percent and
// span, reciprocal multiply for the divide by 100, window edges, then the drive
// decision that updates the control state. one transaction per cycle unless stalled.
// the drive state is only updated at the last stage, so items stay in order and
// a start followed directly by samples works at full rate.
// when the receiver stalls, the output register holds; stages behind it keep
// filling bubbles and in_stall_o rises only when the first stage cannot move.
// configuration uses an apb-style port (registers at 4*i, pready always high)
// and must only be written while no transaction is in flight.
// reset clears the pipeline, sets the registers to their defaults and leaves
// the motor stopped with no move in progress.
module motor_fader_position_control_top
  import mfpc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  fader_in_t   in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output fader_out_t  out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // configuration registers
  logic [9:0] fader_min_q, fader_max_q, tolerance_q, dist_far_q, dist_near_q;
  logic [7:0] speed_far_q, speed_mid_q, speed_near_q;
  logic       cfg_wr;
  logic [2:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fader_min_q  <= 10'd0;
      fader_max_q  <= 10'd1023;
      tolerance_q  <= 10'd8;
      speed_far_q  <= 8'd255;
      speed_mid_q  <= 8'd180;
      speed_near_q <= 8'd120;
      dist_far_q   <= 10'd200;
      dist_near_q  <= 10'd50;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_FADER_MIN:  fader_min_q  <= pwdata[9:0];
        REG_FADER_MAX:  fader_max_q  <= pwdata[9:0];
        REG_TOLERANCE:  tolerance_q  <= pwdata[9:0];
        REG_SPEED_FAR:  speed_far_q  <= pwdata[7:0];
        REG_SPEED_MID:  speed_mid_q  <= pwdata[7:0];
        REG_SPEED_NEAR: speed_near_q <= pwdata[7:0];
        REG_DIST_FAR:   dist_far_q   <= pwdata[9:0];
        REG_DIST_NEAR:  dist_near_q  <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_FADER_MIN:  prdata = {22'd0, fader_min_q};
      REG_FADER_MAX:  prdata = {22'd0, fader_max_q};
      REG_TOLERANCE:  prdata = {22'd0, tolerance_q};
      REG_SPEED_FAR:  prdata = {24'd0, speed_far_q};
      REG_SPEED_MID:  prdata = {24'd0, speed_mid_q};
      REG_SPEED_NEAR: prdata = {24'd0, speed_near_q};
      REG_DIST_FAR:   prdata = {22'd0, dist_far_q};
      REG_DIST_NEAR:  prdata = {22'd0, dist_near_q};
      default:        prdata = 32'd0;
    endcase
  end

  // pipeline flow control, bubbles collapse behind a stalled output
  logic s1_valid_q, s2_valid_q, s3_valid_q, out_valid_q;
  logic out_free, s3_free, s2_free, s1_free, in_accept;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s3_free    = !s3_valid_q || out_free;
  assign s2_free    = !s2_valid_q || s3_free;
  assign s1_free    = !s1_valid_q || s2_free;
  assign in_stall_o = !s1_free;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_free) s1_valid_q  <= in_valid_i;
      if (s2_free) s2_valid_q  <= s1_valid_q;
      if (s3_free) s3_valid_q  <= s2_valid_q;
      if (out_free) out_valid_q <= s3_valid_q;
    end
  end

  // stage 1: percent times magnitude of the span
  fader_in_t          s1_item_q, s2_item_q, s3_item_q;
  logic signed [10:0] span;
  logic        [9:0]  span_mag;
  logic        [16:0] prod_d, prod_q;
  logic               neg1_q, neg2_q;

  assign span     = $signed({1'b0, fader_max_q}) - $signed({1'b0, fader_min_q});
  assign span_mag = span[10] ? 10'(-span) : span[9:0];
  assign prod_d   = 17'(in_data_i.target_percent) * 17'(span_mag);

  always_ff @(posedge clk_i) begin
    if (s1_free) begin
      s1_item_q <= in_data_i;
      prod_q    <= prod_d;
      neg1_q    <= span[10];
    end
  end

  // stage 2: truncating divide by 100
  logic [34:0] recip_full;
  logic [10:0] quot_q;

  assign recip_full = 35'(prod_q) * 35'(PCT_RECIP);

  always_ff @(posedge clk_i) begin
    if (s2_free) begin
      s2_item_q <= s1_item_q;
      quot_q    <= recip_full[RECIP_SHIFT +: 11];
      neg2_q    <= neg1_q;
    end
  end

  // stage 3: window edges around the scaled target
  logic signed [WIN_W-1:0] centre, win_lo_d, win_hi_d, win_lo_s3_q, win_hi_s3_q;
  logic signed [WIN_W-1:0] quot_s, tol_s;

  assign quot_s   = neg2_q ? -$signed({2'b00, quot_q}) : $signed({2'b00, quot_q});
  assign tol_s    = $signed({3'b000, tolerance_q});
  assign centre   = $signed({3'b000, fader_min_q}) + quot_s;
  assign win_lo_d = centre - tol_s;
  assign win_hi_d = centre + tol_s;

  always_ff @(posedge clk_i) begin
    if (s3_free) begin
      s3_item_q   <= s2_item_q;
      win_lo_s3_q <= win_lo_d;
      win_hi_s3_q <= win_hi_d;
    end
  end

  // last stage: drive decision and control state
  logic signed [WIN_W-1:0] win_lo_q, win_hi_q, win_lo_d2, win_hi_d2;
  logic [6:0]              settle_q, settle_d;
  logic [1:0]              dir_q, dir_d;
  logic [7:0]              duty_q, duty_d;
  logic                    moving_q, moving_d;
  logic                    is_start, active, below, above, in_window;
  logic signed [WIN_W-1:0] pos, gap;
  logic [7:0]              picked;
  logic                    state_en;
  fader_out_t              out_q;

  assign state_en = s3_valid_q && out_free;
  assign is_start = (s3_item_q.op == OP_START);
  assign pos      = $signed({3'b000, s3_item_q.sample & SAMPLE_MASK});
  assign active   = is_start || moving_q;

  always_comb begin
    win_lo_d2 = is_start ? win_lo_s3_q : win_lo_q;
    win_hi_d2 = is_start ? win_hi_s3_q : win_hi_q;
    below     = pos < win_lo_d2;
    above     = pos > win_hi_d2;
    in_window = !below && !above;
    gap       = below ? (win_lo_d2 - pos) : (pos - win_hi_d2);
    if (gap > $signed({3'b000, dist_far_q})) begin
      picked = speed_far_q;
    end else if (gap > $signed({3'b000, dist_near_q})) begin
      picked = speed_mid_q;
    end else begin
      picked = speed_near_q;
    end

    settle_d = is_start ? 7'd0 : settle_q;
    duty_d   = is_start ? speed_near_q : duty_q;
    moving_d = is_start ? 1'b1 : moving_q;
    dir_d    = dir_q;
    if (active) begin
      if (in_window && settle_d >= SETTLE_MAX) begin
        dir_d    = DIR_STOP;
        duty_d   = 8'd0;
        moving_d = 1'b0;
        settle_d = 7'd0;
      end else if (below) begin
        duty_d   = picked;
        dir_d    = DIR_UP;
        settle_d = 7'd0;
      end else if (above) begin
        duty_d   = picked;
        dir_d    = DIR_DOWN;
        settle_d = 7'd0;
      end else if (settle_d != SETTLE_SAT) begin
        settle_d = settle_d + 7'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_lo_q <= '0;
      win_hi_q <= '0;
      settle_q <= 7'd0;
      dir_q    <= DIR_STOP;
      duty_q   <= 8'd0;
      moving_q <= 1'b0;
    end else if (state_en) begin
      win_lo_q <= win_lo_d2;
      win_hi_q <= win_hi_d2;
      settle_q <= settle_d;
      dir_q    <= dir_d;
      duty_q   <= duty_d;
      moving_q <= moving_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_en) begin
      out_q.direction <= dir_d;
      out_q.duty      <= duty_d;
      out_q.settled   <= !moving_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // a finished move always leaves the motor stopped
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !moving_q |-> (dir_q == DIR_STOP && duty_q == 8'd0))
    else $error("idle with motor still driven");

  // no invalid direction code reaches the state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dir_q != 2'd3)
    else $error("illegal drive direction");

  // an empty first stage never backpressures the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> !in_stall_o)
    else $error("input stalled with empty first stage");

  // control state only moves when a transaction leaves the last stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !state_en |=> $stable(moving_q) && $stable(settle_q))
    else $error("control state changed without a transaction");

endmodule
